/* rtl/serial_command_line_decoder_unit_assert.svh */
// Assertion macros shared by the serial command line decoder RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef SERIAL_COMMAND_LINE_DECODER_UNIT_ASSERT_SVH
`define SERIAL_COMMAND_LINE_DECODER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SCLCD_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("sclcd: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SCLCD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("sclcd: next-cycle check failed");

`endif

/* rtl/sclcd_pkg.sv */
// Shared types, constants and word tables of the serial command line decoder.
// Depends on nothing; imported by sclcd_line and the top level.
package sclcd_pkg;

    localparam int LINE_MAX  = 32;
    localparam int POS_W     = $clog2(LINE_MAX + 1);
    localparam int CMD_COUNT = 4;

    localparam logic [7:0] CR_BYTE   = 8'h0D;
    localparam logic [7:0] NUL_BYTE  = 8'h00;
    localparam logic [7:0] DIGIT_LO  = 8'h30;
    localparam logic [7:0] DIGIT_HI  = 8'h39;
    localparam logic [7:0] LED_SEL_1 = 8'd1;
    localparam logic [7:0] LED_SEL_2 = 8'd2;

    typedef enum logic [1:0] {
        CMD_LED_ON   = 2'd0,
        CMD_LED_OFF  = 2'd1,
        CMD_BUZZ_ON  = 2'd2,
        CMD_BUZZ_OFF = 2'd3
    } cmd_t;

    typedef struct packed {
        logic       matched;
        cmd_t       command;
        logic [7:0] number;
    } line_status_t;

    // Command words, left-justified and padded with spaces to ten characters.
    localparam logic [79:0] WORD_TEXT [CMD_COUNT] = '{
        "led on    ",
        "led off   ",
        "buzzer on ",
        "buzzer off"
    };

    function automatic logic [3:0] word_len(input logic [1:0] k);
        logic [3:0] len;
        unique case (k)
            2'd0:    len = 4'd6;
            2'd1:    len = 4'd7;
            2'd2:    len = 4'd9;
            default: len = 4'd10;
        endcase
        return len;
    endfunction

    // Character idx of word k; idx must be below the word length.
    function automatic logic [7:0] word_char(input logic [1:0] k, input logic [3:0] idx);
        logic [6:0] sh;
        sh = 7'(4'd9 - idx) << 3;
        return 8'(WORD_TEXT[k] >> sh);
    endfunction

endpackage

/* rtl/sclcd_line.sv */
// Line tracker: live command bits, kept-character count, zero-byte flag, digit fold.
// Depends on sclcd_pkg and serial_command_line_decoder_unit_assert.svh.
`include "serial_command_line_decoder_unit_assert.svh"

module sclcd_line
    import sclcd_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         step,
    input  logic [7:0]   rx_byte,
    output line_status_t status
);

    logic [CMD_COUNT-1:0] live_reg,  live_next;
    logic [POS_W-1:0]     pos_reg,   pos_next;
    logic                 ended_reg, ended_next;
    logic [7:0]           digit_reg, digit_next;

    logic is_cr;
    logic keep;
    logic is_digit;

    assign is_cr    = (rx_byte == CR_BYTE);
    assign keep     = !ended_reg && (pos_reg < POS_W'(LINE_MAX));
    assign is_digit = (rx_byte >= DIGIT_LO) && (rx_byte <= DIGIT_HI);

    always_comb begin
        live_next  = live_reg;
        pos_next   = pos_reg;
        ended_next = ended_reg;
        digit_next = digit_reg;
        if (is_cr) begin
            live_next  = '1;
            pos_next   = '0;
            ended_next = 1'b0;
            digit_next = '0;
        end else if (keep) begin
            if (rx_byte == NUL_BYTE) begin
                ended_next = 1'b1;
            end else begin
                for (int k = 0; k < CMD_COUNT; k++) begin
                    if (pos_reg < POS_W'(word_len(2'(k))) &&
                        word_char(2'(k), pos_reg[3:0]) != rx_byte)
                        live_next[k] = 1'b0;
                end
                if (is_digit)
                    digit_next = (digit_reg << 3) + (digit_reg << 1) + (rx_byte - DIGIT_LO);
                pos_next = pos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            live_reg  <= '1;
            pos_reg   <= '0;
            ended_reg <= 1'b0;
            digit_reg <= '0;
        end else if (step) begin
            live_reg  <= live_next;
            pos_reg   <= pos_next;
            ended_reg <= ended_next;
            digit_reg <= digit_next;
        end
    end

    // Lowest live word that the line fully covers wins.
    always_comb begin
        status = '{matched: 1'b0, command: CMD_LED_ON, number: 8'd0};
        for (int k = CMD_COUNT - 1; k >= 0; k--) begin
            if (live_reg[k] && pos_reg >= POS_W'(word_len(2'(k)))) begin
                status.matched = 1'b1;
                status.command = cmd_t'(2'(k));
            end
        end
        if (status.matched)
            status.number = digit_reg;
    end

    `SCLCD_ASSERT_NOW(a_pos_bound, aclk, aresetn, 1'b1, pos_reg <= POS_W'(LINE_MAX))
    `SCLCD_ASSERT_NEXT(a_cr_clears, aclk, aresetn, step && is_cr,
        pos_reg == '0 && live_reg == '1 && !ended_reg && digit_reg == '0)
    `SCLCD_ASSERT_NEXT(a_ended_holds, aclk, aresetn, ended_reg && !(step && is_cr),
        ended_reg && $stable(pos_reg) && $stable(digit_reg))

endmodule

/* rtl/serial_command_line_decoder_unit.sv */
// Top level of the serial command line decoder: byte input register, line tracker,
// pin logic and result register. Depends on sclcd_pkg, sclcd_line and the assert header.
//
//  channel | ports                                   | beat
//  --------+-----------------------------------------+-----------------------------------
//  input   | s_valid s_ready s_rx_byte               | one received serial byte
//  result  | m_valid m_ready m_matched m_command     | one decoded line, sent on CR
//          | m_number m_led_one m_led_two m_buzzer   |
//
// One byte per cycle sustained while no CR waits for the result register: a byte lands
// in the input register, the line tracker and pin logic consume it from there, and a
// CR writes the result register.
// A non-CR byte is consumed even while a result waits; only a CR waits for the
// result register to drain. Reset (aresetn low, synchronous) clears the line, the
// pin levels and m_valid; the result registers that drive the pin outputs are not reset.
`include "serial_command_line_decoder_unit_assert.svh"

module serial_command_line_decoder_unit
    import sclcd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,

    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,

    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_matched,
    output logic [1:0] m_command,
    output logic [7:0] m_number,
    output logic       m_led_one,
    output logic       m_led_two,
    output logic       m_buzzer
);

    // Input register.
    logic       byte_valid_reg;
    logic [7:0] byte_reg;

    // Pin levels: bit 0 LED one, bit 1 LED two, bit 2 buzzer.
    logic [2:0] pins_reg, pins_next;

    // Result register.
    logic       out_valid_reg;
    logic       out_matched_reg;
    cmd_t       out_command_reg;
    logic [7:0] out_number_reg;
    logic [2:0] out_pins_reg;

    logic         out_free;
    logic         byte_is_cr;
    logic         proc;
    logic         proc_cr;
    line_status_t status;

    assign out_free   = !out_valid_reg || m_ready;
    assign byte_is_cr = (byte_reg == CR_BYTE);
    // Consume the held byte; a CR also needs room in the result register.
    assign proc       = byte_valid_reg && (out_free || !byte_is_cr);
    assign proc_cr    = proc && byte_is_cr;
    assign s_ready    = !byte_valid_reg || proc;

    sclcd_line u_line (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (proc),
        .rx_byte (byte_reg),
        .status  (status)
    );

    // Run the matched command on the pins.
    always_comb begin
        pins_next = pins_reg;
        if (status.matched) begin
            unique case (status.command)
                CMD_LED_ON: begin
                    if (status.number == LED_SEL_1)      pins_next[0] = 1'b1;
                    else if (status.number == LED_SEL_2) pins_next[1] = 1'b1;
                end
                CMD_LED_OFF: begin
                    if (status.number == LED_SEL_1)      pins_next[0] = 1'b0;
                    else if (status.number == LED_SEL_2) pins_next[1] = 1'b0;
                end
                CMD_BUZZ_ON:  pins_next[2] = 1'b1;
                CMD_BUZZ_OFF: pins_next[2] = 1'b0;
                default:      pins_next    = pins_reg;
            endcase
        end
    end

    // Control state and input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            pins_reg       <= '0;
        end else begin
            // Load a new beat whenever the held one is consumed or absent.
            if (s_ready)
                byte_valid_reg <= s_valid;
            if (proc_cr) begin
                out_valid_reg <= 1'b1;
                pins_reg      <= pins_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: no reset needed.
    always_ff @(posedge aclk) begin
        if (s_ready && s_valid)
            byte_reg <= s_rx_byte;
        if (proc_cr) begin
            out_matched_reg <= status.matched;
            out_command_reg <= status.command;
            out_number_reg  <= status.number;
            out_pins_reg    <= pins_next;
        end
    end

    assign m_valid   = out_valid_reg;
    assign m_matched = out_matched_reg;
    assign m_command = out_command_reg;
    assign m_number  = out_number_reg;
    assign m_led_one = out_pins_reg[0];
    assign m_led_two = out_pins_reg[1];
    assign m_buzzer  = out_pins_reg[2];

    `SCLCD_ASSERT_NEXT(a_cr_gives_result, aclk, aresetn, proc_cr,
        m_valid && m_led_one == pins_reg[0] && m_buzzer == pins_reg[2])
    `SCLCD_ASSERT_NOW(a_nomatch_zero, aclk, aresetn, m_valid && !m_matched,
        m_command == CMD_LED_ON && m_number == 8'd0)
    `SCLCD_ASSERT_NEXT(a_pins_only_on_cr, aclk, aresetn, !proc_cr, $stable(pins_reg))
    `SCLCD_ASSERT_NOW(a_buzz_on_sets, aclk, aresetn,
        m_valid && m_matched && m_command == CMD_BUZZ_ON, m_buzzer)

endmodule
